>>> design/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types and constants for the i2c eeprom byte access master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cee_pkg;

   // field widths fixed by the item format
   localparam int MEM_ADDR_W = 11;
   localparam int BYTE_W     = 8;

   // command codes of the request item
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_ACK_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_DEVICE_CODE = 2'd1;
   localparam logic [1:0] CSR_PHASE_TICKS = 2'd2;

   // configuration reset values
   localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
   localparam logic [6:0] DEVICE_CODE_RST = 7'h50;
   localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

   // queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request item
   typedef struct packed {
      logic [1:0]            cmd;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [BYTE_W-1:0]     write_data;
      logic                  sda_in;
   } req_type;

   // result item
   typedef struct packed {
      logic              scl;
      logic              sda_out;
      logic              sda_oe;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_data;
      logic              ack_error;
   } rsp_type;

   // classified item kind
   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_READ,
      KIND_WRITE
   } kind_type;

   // classified item held in the queue
   typedef struct packed {
      kind_type              kind;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [BYTE_W-1:0]     write_data;
      logic                  sda_in;
   } work_type;

endpackage

`default_nettype wire

>>> design/i2cee_front.sv
// ----------------------------------------------------------------------------
// i2cee_front
// accepts request items, decodes the command and trims the address
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cee_front #(
   parameter int ADDR_BITS = 11
) (
   input  wire                 req_valid,
   output logic                req_ready,
   input  i2cee_pkg::req_type  req_payload,
   input  wire                 queue_full,
   output logic                push,
   output i2cee_pkg::work_type push_data
);

   localparam logic [i2cee_pkg::MEM_ADDR_W-1:0] ADDR_MASK =
      i2cee_pkg::MEM_ADDR_W'((1 << ADDR_BITS) - 1);

   // take an item whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // command decode, the unused code counts as a tick
   always_comb begin
      push_data.mem_addr   = req_payload.mem_addr & ADDR_MASK;
      push_data.write_data = req_payload.write_data;
      push_data.sda_in     = req_payload.sda_in;
      unique case (req_payload.cmd)
         i2cee_pkg::CMD_READ:  push_data.kind = i2cee_pkg::KIND_READ;
         i2cee_pkg::CMD_WRITE: push_data.kind = i2cee_pkg::KIND_WRITE;
         default:              push_data.kind = i2cee_pkg::KIND_TICK;
      endcase
   end

endmodule

`default_nettype wire

>>> design/i2cee_queue.sv
// ----------------------------------------------------------------------------
// i2cee_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cee_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  i2cee_pkg::work_type push_data,
   output logic                full,
   input  wire                 pop,
   output logic                pop_valid,
   output i2cee_pkg::work_type pop_data
);

   i2cee_pkg::work_type                   entry_ff [i2cee_pkg::QUEUE_DEPTH];
   logic [i2cee_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [i2cee_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [i2cee_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   localparam logic [i2cee_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      i2cee_pkg::QUEUE_PTR_W'(i2cee_pkg::QUEUE_DEPTH - 1);
   localparam logic [i2cee_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      i2cee_pkg::QUEUE_CNT_W'(i2cee_pkg::QUEUE_DEPTH);

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/i2cee_engine.sv
// ----------------------------------------------------------------------------
// i2cee_engine
// bus sequencer: one queued item advances the pin phase machine one tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cee_engine #(
   parameter int ADDR_BITS = 11
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [1:0]          csr_index,
   input  wire  [7:0]          csr_wdata,
   input  wire                 work_valid,
   input  i2cee_pkg::work_type work_data,
   output logic                pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output i2cee_pkg::rsp_type  rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DEVW,
      ST_ACK1,
      ST_ADDR,
      ST_ACK2,
      ST_DATA,
      ST_ACK3,
      ST_RSTART,
      ST_DEVR,
      ST_ACK4,
      ST_READ,
      ST_NAK,
      ST_STOP
   } step_type;

   step_type                step_ff, step_in;
   logic [1:0]              phase_ff, phase_in;
   logic [7:0]              div_ff, div_in;
   logic [2:0]              bit_ff, bit_in;
   logic [7:0]              shift_ff, shift_in;
   logic [7:0]              ack_cnt_ff, ack_cnt_in;
   logic [ADDR_BITS-1:0]    addr_ff, addr_in;
   logic [7:0]              data_ff, data_in;
   logic                    read_mode_ff, read_mode_in;
   logic                    error_ff, error_in;
   logic [7:0]              ack_timeout_ff;
   logic [6:0]              device_code_ff;
   logic [7:0]              phase_ticks_ff;
   logic                    rsp_valid_ff;
   i2cee_pkg::rsp_type      rsp_ff, rsp_in;

   logic [7:0]              limit;
   logic                    done;
   logic                    is_ack;
   logic                    is_send;
   logic                    mid;

   // device byte: code plus high address bits, shifted up, with r/w bit
   function automatic logic [7:0] dev_byte(input logic [6:0] code, input logic [2:0] hi,
                                           input logic rd);
      logic [6:0] sum;
      sum = code + {4'd0, hi};
      return {sum, rd};
   endfunction

   assign csr_ready   = 1'b1;
   assign pop         = work_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign limit       = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;

   assign is_ack  = (step_ff == ST_ACK1) || (step_ff == ST_ACK2) ||
                    (step_ff == ST_ACK3) || (step_ff == ST_ACK4);
   assign is_send = (step_ff == ST_DEVW) || (step_ff == ST_ADDR) ||
                    (step_ff == ST_DATA) || (step_ff == ST_DEVR);

   // next state for one tick
   always_comb begin
      step_in      = step_ff;
      phase_in     = phase_ff;
      div_in       = div_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      ack_cnt_in   = ack_cnt_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      read_mode_in = read_mode_ff;
      error_in     = error_ff;
      done         = 1'b0;
      if (pop) begin
         if (step_ff == ST_IDLE) begin
            // request start while idle
            if (work_data.kind == i2cee_pkg::KIND_READ ||
                work_data.kind == i2cee_pkg::KIND_WRITE) begin
               addr_in      = work_data.mem_addr[ADDR_BITS-1:0];
               data_in      = work_data.write_data;
               read_mode_in = (work_data.kind == i2cee_pkg::KIND_READ);
               error_in     = 1'b0;
               step_in      = ST_START;
               phase_in     = 2'd0;
               div_in       = 8'd0;
               bit_in       = 3'd0;
               ack_cnt_in   = 8'd0;
               shift_in     = dev_byte(device_code_ff, 3'(addr_in >> 8), 1'b0);
            end
         end else if (is_ack && phase_ff == 2'd2) begin
            // acknowledge wait, sampled every tick
            if (!work_data.sda_in) begin
               phase_in   = 2'd3;
               div_in     = 8'd0;
               ack_cnt_in = 8'd0;
            end else if (ack_cnt_ff >= ack_timeout_ff) begin
               error_in   = 1'b1;
               step_in    = ST_STOP;
               phase_in   = 2'd0;
               div_in     = 8'd0;
               bit_in     = 3'd0;
               ack_cnt_in = 8'd0;
            end else begin
               ack_cnt_in = ack_cnt_ff + 8'd1;
            end
         end else begin
            div_in = div_ff + 8'd1;
            if (div_in >= limit) begin
               div_in = 8'd0;
               if (phase_ff != 2'd3) begin
                  if (step_ff == ST_READ && phase_ff == 2'd2) begin
                     shift_in = {shift_ff[6:0], work_data.sda_in};
                  end
                  phase_in = phase_ff + 2'd1;
               end else if (is_send || step_ff == ST_READ) begin
                  // end of a data bit
                  if (is_send) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                  end
                  bit_in   = bit_ff + 3'd1;
                  phase_in = 2'd0;
                  if (bit_in == 3'd0) begin
                     ack_cnt_in = 8'd0;
                     case (step_ff)
                        ST_DEVW: step_in = ST_ACK1;
                        ST_ADDR: step_in = ST_ACK2;
                        ST_DATA: step_in = ST_ACK3;
                        ST_DEVR: step_in = ST_ACK4;
                        default: step_in = ST_NAK;
                     endcase
                  end
               end else begin
                  // end of a framing or acknowledge symbol
                  phase_in   = 2'd0;
                  bit_in     = 3'd0;
                  ack_cnt_in = 8'd0;
                  unique case (step_ff)
                     ST_START: step_in = ST_DEVW;
                     ST_ACK1: begin
                        step_in  = ST_ADDR;
                        shift_in = addr_ff[7:0];
                     end
                     ST_ACK2: begin
                        if (read_mode_ff) begin
                           step_in = ST_RSTART;
                        end else begin
                           step_in  = ST_DATA;
                           shift_in = data_ff;
                        end
                     end
                     ST_ACK3:   step_in = ST_STOP;
                     ST_RSTART: begin
                        step_in  = ST_DEVR;
                        shift_in = dev_byte(device_code_ff, 3'(addr_ff >> 8), 1'b1);
                     end
                     ST_ACK4: begin
                        step_in  = ST_READ;
                        shift_in = 8'd0;
                     end
                     ST_NAK:  step_in = ST_STOP;
                     default: begin
                        step_in = ST_IDLE;
                        done    = 1'b1;
                     end
                  endcase
               end
            end
         end
      end
   end

   // pin levels after the tick
   assign mid = (phase_in == 2'd1) || (phase_in == 2'd2);

   always_comb begin
      rsp_in.scl       = 1'b1;
      rsp_in.sda_out   = 1'b1;
      rsp_in.sda_oe    = 1'b1;
      rsp_in.busy_res  = (step_in != ST_IDLE);
      rsp_in.done_res  = done;
      rsp_in.read_data = (done && read_mode_in && !error_in) ? shift_in : 8'd0;
      rsp_in.ack_error = done && error_in;
      unique case (step_in)
         ST_IDLE: rsp_in.sda_oe = 1'b0;
         ST_START: begin
            rsp_in.scl     = (phase_in != 2'd3);
            rsp_in.sda_out = (phase_in < 2'd2);
         end
         ST_RSTART: begin
            rsp_in.scl     = mid;
            rsp_in.sda_out = (phase_in < 2'd2);
         end
         ST_STOP: begin
            rsp_in.scl     = (phase_in != 2'd0);
            rsp_in.sda_out = (phase_in >= 2'd2);
         end
         ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR: begin
            rsp_in.scl     = mid;
            rsp_in.sda_out = shift_in[7];
         end
         ST_ACK1, ST_ACK2, ST_ACK3, ST_ACK4, ST_READ: begin
            rsp_in.scl    = mid;
            rsp_in.sda_oe = 1'b0;
         end
         ST_NAK:  rsp_in.scl = mid;
         default: rsp_in.scl = mid;
      endcase
   end

   // state, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= ST_IDLE;
         phase_ff       <= 2'd0;
         div_ff         <= 8'd0;
         bit_ff         <= 3'd0;
         shift_ff       <= 8'd0;
         ack_cnt_ff     <= 8'd0;
         addr_ff        <= '0;
         data_ff        <= 8'd0;
         read_mode_ff   <= 1'b0;
         error_ff       <= 1'b0;
         ack_timeout_ff <= i2cee_pkg::ACK_TIMEOUT_RST;
         device_code_ff <= i2cee_pkg::DEVICE_CODE_RST;
         phase_ticks_ff <= i2cee_pkg::PHASE_TICKS_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         div_ff       <= div_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         ack_cnt_ff   <= ack_cnt_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         read_mode_ff <= read_mode_in;
         error_ff     <= error_in;
         if (csr_valid) begin
            case (csr_index)
               i2cee_pkg::CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_wdata;
               i2cee_pkg::CSR_DEVICE_CODE: device_code_ff <= csr_wdata[6:0];
               i2cee_pkg::CSR_PHASE_TICKS: phase_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

>>> design/i2c_eeprom_byte_access_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master
// i2c master for single byte random reads and writes to a 24xx eeprom
// ----------------------------------------------------------------------------
// channel   direction  ports                               accepted when
// req       in         req_valid req_ready req_payload     req_valid & req_ready
// rsp       out        rsp_valid rsp_ready rsp_payload     rsp_valid & rsp_ready
// csr       in         csr_valid csr_ready csr_index/wdata csr_valid & csr_ready
//
// one item per clock sustained while rsp_ready is held high; a taken item is
// written into the two-entry queue, and its result is registered when the
// engine pops it, which waits while an earlier result is stalled
// reset is synchronous and puts the bus idle with default configuration
// the queue keeps taking items while a result waits, until it holds two
// csr writes are always taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_access_master #(
   parameter int ADDR_BITS = 11
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  i2cee_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output i2cee_pkg::rsp_type rsp_payload,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [1:0]         csr_index,
   input  wire  [7:0]         csr_wdata
);

   logic                queue_full;
   logic                push;
   i2cee_pkg::work_type push_data;
   logic                pop;
   logic                pop_valid;
   i2cee_pkg::work_type pop_data;

   // front: accept and classify
   i2cee_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // queue between the two sides
   i2cee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // back: bus sequencer
   i2cee_engine #(
      .ADDR_BITS (ADDR_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .work_valid  (pop_valid),
      .work_data   (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> design/i2cee_checker.sv
// ----------------------------------------------------------------------------
// i2cee_checker
// port level checks on the result channel of the eeprom master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cee_checker (
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input i2cee_pkg::rsp_type rsp_payload
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   // a finished transfer leaves the bus idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res |->
         !rsp_payload.busy_res && rsp_payload.scl && !rsp_payload.sda_oe)
      else $error("done without idle bus");

   // released sda reads as high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.sda_oe |-> rsp_payload.sda_out)
      else $error("sda_out low while released");

   // error flag only with done
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.ack_error |-> rsp_payload.done_res)
      else $error("ack_error without done");

   // read byte only shown with done
   a_data_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.read_data != 8'd0) |->
         rsp_payload.done_res && !rsp_payload.ack_error)
      else $error("read_data outside a finished read");

endmodule

bind i2c_eeprom_byte_access_master i2cee_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/i2c_eeprom_byte_access_master_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_tb
// drives request items through the master with bursty valid and a stalling
// receiver, predicts the pin levels and completion flags of every item with
// an in-bench model of the i2c sequencer, and checks each result item in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module i2c_eeprom_byte_access_master_tb;

   localparam int ADDR_BITS   = 11;
   localparam int QUIET_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   // command code with no meaning, handled as a tick
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // pin tables of start and stop symbols, indexed by pin phase
   localparam logic [3:0] START_SCL = 4'b0111;
   localparam logic [3:0] START_SDA = 4'b0011;
   localparam logic [3:0] STOP_SCL  = 4'b1110;
   localparam logic [3:0] STOP_SDA  = 4'b1100;

   // steps of one random access transfer
   typedef enum logic [4:0] {
      BUS_IDLE,
      BUS_START,
      BUS_DEV_WR,
      BUS_ACK_DEV,
      BUS_ADDR_LO,
      BUS_ACK_ADDR,
      BUS_DATA,
      BUS_ACK_DATA,
      BUS_RESTART,
      BUS_DEV_RD,
      BUS_ACK_DEV_RD,
      BUS_READ,
      BUS_NAK,
      BUS_STOP
   } bus_step_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   i2cee_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   i2cee_pkg::rsp_type rsp_payload;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index   = i2cee_pkg::CSR_ACK_TIMEOUT;
   logic [7:0]         csr_wdata   = 8'd0;

   i2cee_pkg::req_type pending_reqs[$];
   i2cee_pkg::rsp_type expected_pins[$];
   int      fail_count  = 0;
   int      quiet_cycles = 0;

   // model of the sequencer: configuration and state
   logic [7:0]                       cfg_ack_timeout;
   logic [6:0]                       cfg_device_code;
   logic [7:0]                       cfg_phase_ticks;
   bus_step_type                     bus_step;
   logic [1:0]                       pin_phase;
   logic [7:0]                       phase_div;
   logic [2:0]                       bit_count;
   logic [7:0]                       shift_reg;
   logic [7:0]                       ack_count;
   logic [i2cee_pkg::MEM_ADDR_W-1:0] addr_hold;
   logic [7:0]                       data_hold;
   logic                             read_mode;
   logic                             error_flag;

   i2c_eeprom_byte_access_master #(
      .ADDR_BITS(ADDR_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // sequencer model
   // ---------------------------------------------------------------------------

   function automatic void reset_bus_model();
      cfg_ack_timeout = i2cee_pkg::ACK_TIMEOUT_RST;
      cfg_device_code = i2cee_pkg::DEVICE_CODE_RST;
      cfg_phase_ticks = i2cee_pkg::PHASE_TICKS_RST;
      bus_step   = BUS_IDLE;
      pin_phase  = '0;
      phase_div  = '0;
      bit_count  = '0;
      shift_reg  = '0;
      ack_count  = '0;
      addr_hold  = '0;
      data_hold  = '0;
      read_mode  = 1'b0;
      error_flag = 1'b0;
   endfunction

   // device byte: code plus high address bits, shifted up, r/w in bit 0
   function automatic logic [7:0] device_byte(input logic rd);
      logic [7:0] hi;
      logic [7:0] sum;
      hi  = 8'((addr_hold >> 8) & ((1 << (ADDR_BITS - 8)) - 1));
      sum = {1'b0, cfg_device_code} + hi;
      return {sum[6:0], rd};
   endfunction

   function automatic void enter_step(input bus_step_type s);
      bus_step  = s;
      pin_phase = '0;
      phase_div = '0;
      bit_count = '0;
      ack_count = '0;
   endfunction

   function automatic logic is_ack_step(input bus_step_type s);
      return s == BUS_ACK_DEV || s == BUS_ACK_ADDR || s == BUS_ACK_DATA || s == BUS_ACK_DEV_RD;
   endfunction

   // end of pin phase 3, true when the stop has completed
   function automatic logic finish_symbol();
      logic fin;
      fin = 1'b0;
      case (bus_step)
         BUS_DEV_WR, BUS_ADDR_LO, BUS_DATA, BUS_DEV_RD, BUS_READ: begin
            if (bus_step != BUS_READ) shift_reg = shift_reg << 1;
            bit_count = bit_count + 3'd1;
            pin_phase = '0;
            if (bit_count == 3'd0) begin
               case (bus_step)
                  BUS_DEV_WR:  enter_step(BUS_ACK_DEV);
                  BUS_ADDR_LO: enter_step(BUS_ACK_ADDR);
                  BUS_DATA:    enter_step(BUS_ACK_DATA);
                  BUS_DEV_RD:  enter_step(BUS_ACK_DEV_RD);
                  default:     enter_step(BUS_NAK);
               endcase
            end
         end
         BUS_START: enter_step(BUS_DEV_WR);
         BUS_ACK_DEV: begin
            enter_step(BUS_ADDR_LO);
            shift_reg = addr_hold[7:0];
         end
         BUS_ACK_ADDR: begin
            if (read_mode) begin
               enter_step(BUS_RESTART);
            end else begin
               enter_step(BUS_DATA);
               shift_reg = data_hold;
            end
         end
         BUS_ACK_DATA: enter_step(BUS_STOP);
         BUS_RESTART: begin
            enter_step(BUS_DEV_RD);
            shift_reg = device_byte(1'b1);
         end
         BUS_ACK_DEV_RD: begin
            enter_step(BUS_READ);
            shift_reg = '0;
         end
         BUS_NAK: enter_step(BUS_STOP);
         default: begin
            enter_step(BUS_IDLE);
            fin = 1'b1;
         end
      endcase
      return fin;
   endfunction

   // one item through the sequencer, returns the pins after it
   function automatic i2cee_pkg::rsp_type step_bus_master(input i2cee_pkg::req_type it);
      i2cee_pkg::rsp_type r;
      logic [7:0]         limit;
      logic               fin;
      logic               mid;
      fin   = 1'b0;
      limit = (cfg_phase_ticks == 8'd0) ? 8'd1 : cfg_phase_ticks;
      if (bus_step == BUS_IDLE) begin
         if (it.cmd == i2cee_pkg::CMD_READ || it.cmd == i2cee_pkg::CMD_WRITE) begin
            addr_hold  = it.mem_addr & i2cee_pkg::MEM_ADDR_W'((1 << ADDR_BITS) - 1);
            data_hold  = it.write_data;
            read_mode  = (it.cmd == i2cee_pkg::CMD_READ);
            error_flag = 1'b0;
            enter_step(BUS_START);
            shift_reg  = device_byte(1'b0);
         end
      end else if (is_ack_step(bus_step) && pin_phase == 2'd2) begin
         // acknowledge wait, sampled every tick
         if (!it.sda_in) begin
            pin_phase = 2'd3;
            phase_div = '0;
            ack_count = '0;
         end else if (ack_count >= cfg_ack_timeout) begin
            error_flag = 1'b1;
            enter_step(BUS_STOP);
         end else begin
            ack_count = ack_count + 8'd1;
         end
      end else begin
         phase_div = phase_div + 8'd1;
         if (phase_div >= limit) begin
            phase_div = '0;
            if (pin_phase != 2'd3) begin
               if (bus_step == BUS_READ && pin_phase == 2'd2)
                  shift_reg = {shift_reg[6:0], it.sda_in};
               pin_phase = pin_phase + 2'd1;
            end else begin
               fin = finish_symbol();
            end
         end
      end

      // pin levels for the new step and phase
      mid = (pin_phase == 2'd1 || pin_phase == 2'd2);
      r = '0;
      r.scl     = 1'b1;
      r.sda_out = 1'b1;
      r.sda_oe  = 1'b1;
      case (bus_step)
         BUS_IDLE: r.sda_oe = 1'b0;
         BUS_START: begin
            r.scl     = START_SCL[pin_phase];
            r.sda_out = START_SDA[pin_phase];
         end
         BUS_RESTART: begin
            r.scl     = (pin_phase == 2'd0) ? 1'b0 : START_SCL[pin_phase];
            r.sda_out = START_SDA[pin_phase];
         end
         BUS_STOP: begin
            r.scl     = STOP_SCL[pin_phase];
            r.sda_out = STOP_SDA[pin_phase];
         end
         BUS_DEV_WR, BUS_ADDR_LO, BUS_DATA, BUS_DEV_RD: begin
            r.scl     = mid;
            r.sda_out = shift_reg[7];
         end
         BUS_ACK_DEV, BUS_ACK_ADDR, BUS_ACK_DATA, BUS_ACK_DEV_RD, BUS_READ: begin
            r.scl    = mid;
            r.sda_oe = 1'b0;
         end
         default: r.scl = mid;
      endcase
      r.busy_res  = (bus_step != BUS_IDLE);
      r.done_res  = fin;
      r.read_data = (fin && read_mode && !error_flag) ? shift_reg : 8'd0;
      r.ack_error = fin & error_flag;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: bursts with random gaps
   // ---------------------------------------------------------------------------

   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_payload <= pending_reqs.pop_front();
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result receiver: ready follows a rotating pattern, renewed each time stall_slot wraps
   // ---------------------------------------------------------------------------

   logic [31:0] stall_pattern = '0;
   logic [4:0]  stall_slot    = '0;

   function automatic logic [31:0] fresh_stall_pattern();
      case ($urandom_range(0, 3))
         0:       return '1;
         1:       return $urandom;
         2:       return $urandom | $urandom;
         default: return $urandom & $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_ready     <= stall_pattern[0];
      stall_pattern <= (stall_slot == 5'd31) ? fresh_stall_pattern()
                                             : {stall_pattern[0], stall_pattern[31:1]};
      stall_slot    <= stall_slot + 5'd1;
   end

   // ---------------------------------------------------------------------------
   // monitor: predict on accepted requests, check accepted results
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      i2cee_pkg::rsp_type want;
      if (reset) begin
         reset_bus_model();
         expected_pins.delete();
         quiet_cycles <= 0;
      end else begin
         // configuration writes land between items
         if (csr_valid && csr_ready) begin
            case (csr_index)
               i2cee_pkg::CSR_ACK_TIMEOUT: cfg_ack_timeout = csr_wdata;
               i2cee_pkg::CSR_DEVICE_CODE: cfg_device_code = csr_wdata[6:0];
               i2cee_pkg::CSR_PHASE_TICKS: cfg_phase_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_pins.push_back(step_bus_master(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_pins.size() == 0) begin
               if (fail_count < REPORT_MAX) $display("unexpected result item at %0t", $realtime);
               fail_count = fail_count + 1;
            end else begin
               want = expected_pins.pop_front();
               if (rsp_payload.scl !== want.scl || rsp_payload.sda_out !== want.sda_out ||
                   rsp_payload.sda_oe !== want.sda_oe || rsp_payload.busy_res !== want.busy_res ||
                   rsp_payload.done_res !== want.done_res ||
                   rsp_payload.read_data !== want.read_data ||
                   rsp_payload.ack_error !== want.ack_error) begin
                  if (fail_count < REPORT_MAX) begin
                     $write("result mismatch at %0t: scl/sda/oe/busy/done/data/err",
                            $realtime);
                     $display(" exp %b %b %b %b %b %h %b got %b %b %b %b %b %h %b",
                              want.scl, want.sda_out, want.sda_oe, want.busy_res,
                              want.done_res, want.read_data, want.ack_error,
                              rsp_payload.scl, rsp_payload.sda_out, rsp_payload.sda_oe,
                              rsp_payload.busy_res, rsp_payload.done_res,
                              rsp_payload.read_data, rsp_payload.ack_error);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog on cycles with no item moving anywhere
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   task automatic queue_item(input logic [1:0] cmd,
                             input logic [i2cee_pkg::MEM_ADDR_W-1:0] addr,
                             input logic [7:0] data, input logic sda);
      i2cee_pkg::req_type it;
      it.cmd        = cmd;
      it.mem_addr   = addr;
      it.write_data = data;
      it.sda_in     = sda;
      pending_reqs.push_back(it);
   endtask

   // a request followed by ticks; the sda style decides acks and read bits
   task automatic queue_transfer(input int n_items);
      int         style;
      int         k;
      logic [1:0] cmd;
      logic       sda;
      style = $urandom_range(0, 9);
      for (k = 0; k < n_items; k++) begin
         if (k == 0) begin
            cmd = $urandom_range(0, 1) ? i2cee_pkg::CMD_READ : i2cee_pkg::CMD_WRITE;
         end else if ($urandom_range(0, 19) == 0) begin
            // stray command, ignored while busy
            case ($urandom_range(0, 2))
               0:       cmd = i2cee_pkg::CMD_READ;
               1:       cmd = i2cee_pkg::CMD_WRITE;
               default: cmd = CMD_UNUSED;
            endcase
         end else begin
            cmd = i2cee_pkg::CMD_TICK;
         end
         if (style <= 6)      sda = ($urandom_range(0, 7) == 0);
         else if (style <= 8) sda = $urandom_range(0, 1);
         else                 sda = 1'b1;
         queue_item(cmd, i2cee_pkg::MEM_ADDR_W'($urandom), 8'($urandom), sda);
      end
   endtask

   // wait until no item is in flight, then let the pipeline settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_pins.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one configuration setting and a run of transfers under it
   task automatic run_setting(input logic [7:0] ack_to, input logic [7:0] dev_code,
                              input logic [7:0] ticks, input int budget);
      int count;
      int n;
      int per_phase;
      wait_quiet();
      write_csr(i2cee_pkg::CSR_ACK_TIMEOUT, ack_to);
      write_csr(i2cee_pkg::CSR_DEVICE_CODE, dev_code);
      write_csr(i2cee_pkg::CSR_PHASE_TICKS, ticks);
      per_phase = (ticks == 8'd0) ? 1 : ticks;
      count = 0;
      while (count < budget) begin
         n = $urandom_range(100, 180) * per_phase;
         if (n > budget - count) n = budget - count;
         queue_transfer(n);
         count = count + n;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: idle ticks, unused command, read at lowest address,
      // requests and unused command while busy, then a run of ticks
      queue_item(i2cee_pkg::CMD_TICK, '0, 8'h00, 1'b0);
      queue_item(i2cee_pkg::CMD_TICK, '1, 8'hff, 1'b1);
      queue_item(CMD_UNUSED, '1, 8'hff, 1'b1);
      queue_item(i2cee_pkg::CMD_READ, '0, 8'h00, 1'b0);
      queue_item(i2cee_pkg::CMD_WRITE, '1, 8'hff, 1'b1);
      queue_item(i2cee_pkg::CMD_READ, '1, 8'hff, 1'b0);
      queue_item(CMD_UNUSED, '0, 8'h00, 1'b0);
      repeat (17) queue_item(i2cee_pkg::CMD_TICK, i2cee_pkg::MEM_ADDR_W'($urandom),
                             8'($urandom), 1'b0);

      // settings: extremes of every register, zero phase ticks, a slow bus
      // phase left mid transfer and picked up again at full speed
      run_setting(8'd0, 8'h7f, 8'd1, 140);
      run_setting(8'd255, 8'h00, 8'd0, 140);
      run_setting(8'($urandom_range(1, 20)), {1'($urandom), 7'h50}, 8'd2, 160);
      run_setting(8'($urandom), 8'($urandom), 8'd255, 280);
      run_setting(8'd250, 8'($urandom), 8'd1, 160);

      wait_quiet();
      repeat (8) @(posedge clock);
      fail_count = fail_count + expected_pins.size();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
